### rtl/stab_pkg.sv
package stab_pkg;

   localparam int DEF_CAPACITY = 64;
   localparam int VALUE_W      = 32;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int COUNT_OUT_W  = 7;
   // Cells per match-reduction group; groups are ORed in the update cycle.
   localparam int GROUP_SIZE   = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_COMPARE,
      FSM_APPLY
   } fsm_state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;     // capture request operands
      logic compare;  // register per-cell compare flags
      logic apply;    // update table, count and response
   } ctl_type;

endpackage

### rtl/stab_controller.sv
module stab_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output stab_pkg::ctl_type ctl,
   output logic              rsp_strobe
);
   import stab_pkg::*;

   fsm_state_type state_ff, state_in;
   logic          strobe_ff, strobe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      ctl         = '0;
      strobe_in   = 1'b0;
      busy        = 1'b1;
      unique case (state_ff)
         FSM_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctl.load = 1'b1;
               state_in = FSM_COMPARE;
            end
         end
         FSM_COMPARE: begin
            ctl.compare = 1'b1;
            state_in    = FSM_APPLY;
         end
         FSM_APPLY: begin
            ctl.apply = 1'b1;
            strobe_in = 1'b1;
            state_in  = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_strobe = strobe_ff;

endmodule

### rtl/stab_datapath.sv
module stab_datapath #(
   parameter int CAPACITY = stab_pkg::DEF_CAPACITY
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  stab_pkg::ctl_type                    ctl,
   input  logic [stab_pkg::CMD_W-1:0]           req_command,
   input  logic signed [stab_pkg::VALUE_W-1:0]  req_value,
   output logic [stab_pkg::STATUS_W-1:0]        rsp_status,
   output logic [stab_pkg::COUNT_OUT_W-1:0]     rsp_entry_count
);
   import stab_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int NG = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   logic signed [VALUE_W-1:0]  entries_ff [CAPACITY];
   logic signed [VALUE_W-1:0]  entries_in [CAPACITY];
   logic [CW-1:0]              count_ff, count_in;
   logic [CMD_W-1:0]           cmd_ff;
   logic signed [VALUE_W-1:0]  value_ff;
   logic [CAPACITY-1:0]        lt_c, match_c, lt_ff;
   logic [NG-1:0]              group_hit_in, group_hit_ff;
   logic [STATUS_W-1:0]        status_ff;
   logic [COUNT_OUT_W-1:0]     count_out_ff;
   status_type                 status_in;
   logic                       hit, full, do_insert, do_remove;

   // One compare-and-shift cell per entry; neighbors only.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      valid;
      logic signed [VALUE_W-1:0] ins_val, rem_val;

      assign valid   = CW'(i) < count_ff;
      assign lt_c[i] = valid && (entries_ff[i] < value_ff);

      if (i == 0) begin : g_first
         assign match_c[i] = valid && (entries_ff[i] == value_ff);
         assign ins_val    = lt_ff[i] ? entries_ff[i] : value_ff;
      end else begin : g_rest
         // first equal entry sits right at the less-than boundary
         assign match_c[i] = valid && (entries_ff[i] == value_ff) && lt_c[i-1];
         assign ins_val    = lt_ff[i]   ? entries_ff[i] :
                             lt_ff[i-1] ? value_ff      : entries_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign rem_val = entries_ff[i];
      end else begin : g_inner
         assign rem_val = lt_ff[i] ? entries_ff[i] : entries_ff[i+1];
      end

      assign entries_in[i] = do_insert ? ins_val :
                             do_remove ? rem_val : entries_ff[i];
   end

   for (genvar g = 0; g < NG; g++) begin : g_group
      localparam int LO = g * GROUP_SIZE;
      localparam int HI = (LO + GROUP_SIZE > CAPACITY) ? CAPACITY - 1
                                                        : LO + GROUP_SIZE - 1;
      assign group_hit_in[g] = |match_c[HI:LO];
   end

   assign hit       = |group_hit_ff;
   assign full      = count_ff == CW'(CAPACITY);
   assign do_insert = ctl.apply && (cmd_ff == CMD_INSERT) && !full;
   assign do_remove = ctl.apply && (cmd_ff == CMD_REMOVE) && hit;

   always_comb begin
      unique case (cmd_ff)
         CMD_INSERT: begin
            status_in = full ? ST_FULL : ST_OK;
         end
         CMD_SEARCH, CMD_REMOVE: begin
            status_in = hit ? ST_OK : ST_NOT_FOUND;
         end
         default: begin
            status_in = ST_NOT_FOUND;
         end
      endcase
   end

   always_comb begin
      priority if (do_insert) begin
         count_in = count_ff + CW'(1);
      end else if (do_remove) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (ctl.load) begin
         cmd_ff   <= req_command;
         value_ff <= req_value;
      end
      if (ctl.compare) begin
         lt_ff        <= lt_c;
         group_hit_ff <= group_hit_in;
      end
      if (ctl.apply) begin
         status_ff    <= status_in;
         count_out_ff <= COUNT_OUT_W'(count_in);
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_out_ff;

endmodule

### rtl/sorted_table_insert_search_remove_top.sv
// The result strobe rises after the compare and update states, from a register set in update.
// A new start is taken only in idle; busy is high during compare and update.
// Update is one parallel step of the cell row, so rate is independent of CAPACITY.
// Reset (synchronous, active high) empties the table and idles the controller.
// Results are shown for one cycle on rsp_strobe; the receiver cannot stall.
module sorted_table_insert_search_remove_top #(
   parameter int CAPACITY = stab_pkg::DEF_CAPACITY
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [stab_pkg::CMD_W-1:0]           req_command,
   input  logic signed [stab_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_strobe,
   output logic [stab_pkg::STATUS_W-1:0]        rsp_status,
   output logic [stab_pkg::COUNT_OUT_W-1:0]     rsp_entry_count
);
   import stab_pkg::*;

   // Command bundle from the sequencer to the cell row.
   ctl_type ctl;

   // Sequencer: idle -> compare -> update, one transfer in flight at a time.
   stab_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .ctl        (ctl),
      .rsp_strobe (rsp_strobe)
   );

   // Cell row: every entry compares against the operand in parallel, the
   // less-than flags mark the insert point (and the first-match boundary),
   // then the whole row shifts right for insert or left for remove.
   stab_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .req_command     (req_command),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
